// ===== hw/rtl/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hasher.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_APPEND_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data_byte;
    } sha_req_t;

    typedef logic [31:0] word_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha256_front.sv =====
// Front end: classify incoming requests and hold them in a two-entry queue.
`timescale 1ns / 1ps
module sha256_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [7:0]            data_byte,
    output logic                  q_valid,
    input  logic                  q_take,
    output sha256_pkg::sha_req_t  q_req
);
    import sha256_pkg::*;

    sha_req_t  slot_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic      push, pop;
    sha_req_t  req_in;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        req_in.has_byte  = (command == CMD_APPEND) || (command == CMD_APPEND_FINISH);
        req_in.finish    = (command == CMD_APPEND_FINISH) || (command == CMD_FINISH);
        req_in.data_byte = data_byte;
    end

    // drop the unused command at the door
    assign push = in_valid && in_ready && (req_in.has_byte || req_in.finish);
    assign pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== hw/rtl/sha256_back.sv =====
// Back end: block buffer, padding sequencer, round engine and digest output.
`timescale 1ns / 1ps
module sha256_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_take,
    input  sha256_pkg::sha_req_t  q_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic        finishing_reg;
    logic [63:0] bits_reg;
    logic [2:0]  oidx_reg;
    logic        ovalid_reg;
    // pad_lead_reg: the 0x80 byte has gone in
    // len_block_reg: the current block carries the length field
    // pad_done_reg: the length field has gone into the last block
    logic        pad_lead_reg;
    logic        len_block_reg;
    logic        pad_done_reg;

    logic        push;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    word_t       wr, w_new, t1, t2, s0, s1, e1, e0;
    logic [5:0]  fill_inc;

    assign q_take = (state_reg == ST_IDLE);
    assign fill_inc = fill_reg + 6'd1;

    // padding byte for the current fill position
    always_comb
    begin
        if (!pad_lead_reg)
            pad_byte = PAD_BYTE;
        else if (len_block_reg && fill_reg >= LEN_OFFSET)
            pad_byte = bits_reg[8 * (7 - fill_reg[2:0]) +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        wr = w_reg[0];
        e1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        e0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        t1 = v_reg[7] + e1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round_reg] + wr;
        t2 = e0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
           ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        push = 1'b0;
        push_byte = q_req.data_byte;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    push = q_req.has_byte;
                    if (q_req.has_byte && fill_inc == 6'd0)
                        state_next = ST_ROUND;
                    else if (q_req.finish)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                push_byte = pad_byte;
                if (fill_inc == 6'd0)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (finishing_reg && pad_done_reg)
                    state_next = ST_OUT;
                else if (finishing_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready && ovalid_reg && oidx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            w_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8] <= push_byte;
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= (round_reg < 6'd48) ? w_new : w_reg[0];
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_H[i];
            fill_reg      <= 6'd0;
            count_reg     <= '0;
            round_reg     <= 6'd0;
            finishing_reg <= 1'b0;
            bits_reg      <= '0;
            oidx_reg      <= 3'd0;
            ovalid_reg    <= 1'b0;
            pad_lead_reg  <= 1'b0;
            len_block_reg <= 1'b0;
            pad_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
                fill_reg <= fill_inc;
            if (state_reg == ST_IDLE && q_valid)
            begin
                if (q_req.has_byte)
                    count_reg <= count_reg + 61'd1;
                if (q_req.finish)
                begin
                    finishing_reg <= 1'b1;
                    bits_reg <= {(q_req.has_byte ? count_reg + 61'd1 : count_reg), 3'b000};
                end
            end
            // first pad byte is 0x80, then zeros up to the length field
            if (state_reg == ST_PAD)
            begin
                pad_lead_reg <= 1'b1;
                // the length goes in this block if there is room, else in the next
                if (fill_reg < LEN_OFFSET || fill_inc == 6'd0)
                    len_block_reg <= 1'b1;
                if (len_block_reg && fill_reg == LEN_OFFSET + 6'd7)
                    pad_done_reg <= 1'b1;
            end
            if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                if (state_next == ST_OUT)
                begin
                    ovalid_reg <= 1'b1;
                    oidx_reg   <= 3'd0;
                end
            end
            if (state_reg == ST_OUT && ovalid_reg && out_ready)
            begin
                oidx_reg <= oidx_reg + 3'd1;
                if (oidx_reg == 3'd7)
                begin
                    ovalid_reg    <= 1'b0;
                    finishing_reg <= 1'b0;
                    pad_lead_reg  <= 1'b0;
                    len_block_reg <= 1'b0;
                    pad_done_reg  <= 1'b0;
                    count_reg     <= '0;
                    fill_reg      <= 6'd0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= INIT_H[i];
                end
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);
endmodule

// ===== hw/rtl/sha256_byte_stream_hasher_unit.sv =====
// Top level of the SHA-256 byte-stream hasher.
// A byte is absorbed as the back end takes it; a full block then runs the round engine.
// A finishing request pads one byte a cycle, compresses once or twice, then streams
// eight digest words, one per accepted cycle. The back end, with its single round engine,
// takes no new request while it compresses, pads or streams; the two-entry queue holds them. Reset loads
// the initial hash values and empties the request queue; the block buffer is not cleared.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    logic     q_valid, q_take;
    sha_req_t q_req;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    // classify and queue requests
    sha256_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .data_byte (s_tdata),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_req     (q_req)
    );

    // absorb, pad, compress and emit
    sha256_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_req       (q_req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {5'd0, word_index, digest_word};
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the SHA-256 byte-stream hasher unit.
`timescale 1ns / 1ps
module tb_top;
    import sha256_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_beat_t;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       has_known;
        word_t      known0;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Predictor state
    word_t        hs [8];
    word_t        blk [16];
    int unsigned  fill;
    logic [60:0]  nbytes;
    digest_beat_t digest_q [$];
    word_t        known_q [$];

    int errors = 0;
    int fails_total = 0;
    int n_sent = 0;
    int n_msgs = 0;
    int n_words = 0;
    longint cycles = 0;
    int src_idle_pct = 9;
    int snk_idle_pct = 61;
    bit done = 0;

    sha256_byte_stream_hasher_unit u_dut (.*);

    always #1 clk = ~clk;

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        word_t w [16];
        word_t v [8];
        word_t wr, t1, t2, a, b;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 0; i < 8; i++) v[i] = hs[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16) wr = w[r];
            else
            begin
                a = w[(r - 2) & 15];
                b = w[(r - 15) & 15];
                wr = (ror(a, 17) ^ ror(a, 19) ^ (a >> 10)) + w[(r - 7) & 15]
                   + (ror(b, 7) ^ ror(b, 18) ^ (b >> 3)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hs[i] += v[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        if ((fill & 3) == 0) blk[fill >> 2] = '0;
        blk[fill >> 2] |= word_t'(b) << ((3 - (fill & 3)) * 8);
        fill = (fill + 1) & 63;
        if (fill == 0) compress_block();
    endtask

    // Advance the hash model by one accepted request; queue the digest on finish.
    task automatic hash_request(logic [1:0] cmd, logic [7:0] data);
        logic [63:0] bits;
        digest_beat_t d;
        if (cmd == CMD_UNUSED) return;
        if (cmd != CMD_FINISH)
        begin
            absorb_byte(data);
            nbytes = nbytes + 61'd1;
        end
        if (cmd == CMD_APPEND) return;
        bits = {nbytes, 3'b000};
        absorb_byte(PAD_BYTE);
        while (fill != LEN_OFFSET) absorb_byte(8'h00);
        for (int i = 7; i >= 0; i--) absorb_byte(bits[i * 8 +: 8]);
        for (int i = 0; i < 8; i++)
        begin
            d.word = hs[i];
            d.idx = 3'(i);
            d.last = (i == 7);
            digest_q.push_back(d);
        end
        for (int i = 0; i < 8; i++) hs[i] = INIT_H[i];
        fill = 0;
        nbytes = '0;
        n_msgs++;
    endtask

    task automatic report(string what, longint unsigned exp, longint unsigned act);
        fails_total++;
        if (errors < 10)
            $display("mismatch %s: expected %h, got %h at cycle %0d", what, exp, act, cycles);
        errors++;
    endtask

    // Check each accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        digest_beat_t e;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0) report("unexpected word", 0, m_tdata[31:0]);
            else
            begin
                e = digest_q.pop_front();
                n_words++;
                if (m_tdata[31:0] !== e.word) report("digest_word", e.word, m_tdata[31:0]);
                if (m_tdata[34:32] !== e.idx) report("word_index", e.idx, m_tdata[34:32]);
                if (m_tdata[39:35] !== 5'd0) report("padding bits", 0, m_tdata[39:35]);
                if (m_tlast !== e.last) report("last_word", e.last, m_tlast);
                if (e.idx == 3'd0 && known_q.size() > 0)
                begin
                    // Digest of a well-known message: word 0 typed in by hand.
                    if (known_q[0] !== m_tdata[31:0]) report("known digest", known_q[0],
                                                             m_tdata[31:0]);
                    void'(known_q.pop_front());
                end
            end
        end
    end

    // Stall the output side at the current rate.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Hold a request until accepted; idle the input side at random between requests.
    task automatic send(logic [1:0] cmd, logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        hash_request(cmd, data);
        n_sent++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len - 1; i++)
            send(($urandom_range(19) == 0) ? CMD_UNUSED : CMD_APPEND, 8'($urandom));
        if (len == 0 || $urandom_range(1)) 
        begin
            if (len > 0) send(CMD_APPEND, 8'($urandom));
            send(CMD_FINISH, 8'($urandom));
        end
        else send(CMD_APPEND_FINISH, 8'($urandom));
    endtask

    stim_row_t dir [$];

    initial
    begin
        int len;
        for (int i = 0; i < 8; i++) hs[i] = INIT_H[i];
        fill = 0;
        nbytes = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, "abc", unused command, byte extremes.
        dir.push_back('{CMD_FINISH, 8'hff, 1'b1, 32'he3b0c442});
        dir.push_back('{CMD_APPEND, 8'h61, 1'b0, '0});
        dir.push_back('{CMD_UNUSED, 8'h00, 1'b0, '0});
        dir.push_back('{CMD_APPEND, 8'h62, 1'b0, '0});
        dir.push_back('{CMD_APPEND_FINISH, 8'h63, 1'b1, 32'hba7816bf});
        dir.push_back('{CMD_APPEND_FINISH, 8'h00, 1'b0, '0});
        dir.push_back('{CMD_APPEND_FINISH, 8'hff, 1'b0, '0});
        dir.push_back('{CMD_UNUSED, 8'hff, 1'b0, '0});
        dir.push_back('{CMD_APPEND, 8'h55, 1'b0, '0});
        dir.push_back('{CMD_APPEND, 8'haa, 1'b0, '0});
        dir.push_back('{CMD_FINISH, 8'h00, 1'b0, '0});
        foreach (dir[i])
        begin
            if (dir[i].has_known) known_q.push_back(dir[i].known0);
            send(dir[i].cmd, dir[i].data);
        end

        // Random messages; lengths cluster around the 55/56/64-byte pad boundaries.
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 61 : 0;
            snk_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 9 : 0;
            for (int start = n_sent; n_sent - start < 105;)
            begin
                case ($urandom_range(3))
                    0: len = $urandom_range(5);
                    1: len = 54 + $urandom_range(4);
                    2: len = 62 + $urandom_range(4);
                    default: len = $urandom_range(130);
                endcase
                send_message(len);
            end
        end
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        done = 1;
        $display("sent %0d requests in %0d messages, checked %0d digest words",
                 n_sent, n_msgs, n_words);
        $display("covered empty and known messages, pad-boundary lengths, unused commands");
        if (fails_total == 0 && known_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run.
    always @(posedge clk)
        if (!done && cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
endmodule
